>>> src/chtl_pkg.sv
// Package: shared constants, types and command/status structs for the hash table block.
package chtl_pkg;

  localparam int unsigned TableSize   = 1024;
  localparam int unsigned IdxW        = $clog2(TableSize);
  localparam int unsigned MaxKeyChars = 8;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned LenW        = 4;
  localparam int unsigned HashW       = 64;
  localparam int unsigned MultW       = 32;
  localparam int unsigned CharCntW    = $clog2(MaxKeyChars + 1);

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OP_QUERY  = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  localparam logic [1:0] RegHashMult = 2'd0;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;       // zero one bucket head, advance clear pointer
    logic load;        // capture request, start hash
    logic hash_step;   // fold in one character (two half products)
    logic hash_half;   // 0: low product, 1: high product and add
    logic head_rd;     // read bucket head
    logic ent_rd;      // read entry at cur
    logic advance;     // cur <= link, tail <= cur
    logic take_head;   // cur <= head read data
    logic do_insert;   // write new entry, make it the bucket head if the chain is empty
    logic set_result;  // latch result
    status_e result_st;
  } chtl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic cur_zero;
    logic match;
    logic is_insert;
    logic full;
  } chtl_sts_t;

endpackage

>>> src/chained_hash_table_lookup_insert.sv
// Top level: separate-chaining hash table with query and find-or-insert, APB config.
//
// One request at a time. The 64-bit hash folds in each key character as a
// 32x32 low product (S_HLO) and then a high product with the add (S_HHI).
// The hash is then finished, the bucket head read (S_HEAD, S_TAKE) and the
// chain end checked (S_ERD); each chain entry visited takes one registered
// entry memory read and compare (S_ERD, S_CMP), an insert adds S_INS and
// S_LINK, and the result is handed off before the next request is taken.
// After reset a clearing pass zeroes the bucket heads, one per cycle, until
// all 1024 are zero; requests are stalled until it ends. The result register
// holds until taken; a new request is taken once the result has left.
module chained_hash_table_lookup_insert
  import chtl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [KeyW-1:0]   key_chars_i,
  input  logic [LenW-1:0]   key_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [IdxW-1:0]   entry_index_o
);

  logic [MultW-1:0] mult_q;
  chtl_cmd_t cmd;
  chtl_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == RegHashMult) ? mult_q : 32'b0;

  // Config register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= 32'd131;
    end else if (psel && penable && pwrite && paddr == RegHashMult) begin
      mult_q <= pwdata;
    end
  end

  chtl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chtl_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hash_mult_i   (mult_q),
    .operation_i   (operation_i),
    .key_chars_i   (key_chars_i),
    .key_length_i  (key_length_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .entry_index_o (entry_index_o)
  );

`ifndef NO_ASSERTIONS
  // A request is never taken while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request accepted with result pending");
  // Absent and full answers carry index zero.
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_ABSENT || status_o == ST_FULL)) |-> entry_index_o == '0)
    else $error("nonzero index without entry");
  // Found and inserted answers name a real entry.
  a_idx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FOUND || status_o == ST_INSERTED)) |-> entry_index_o != '0)
    else $error("entry answer with index zero");
`endif

endmodule

>>> src/chtl_datapath.sv
// Datapath: hash unit, bucket head and entry memories, chain walk registers.
module chtl_datapath
  import chtl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [MultW-1:0] hash_mult_i,
  input  logic             operation_i,
  input  logic [KeyW-1:0]  key_chars_i,
  input  logic [LenW-1:0]  key_length_i,
  input  chtl_cmd_t        cmd_i,
  output chtl_sts_t        sts_o,
  output logic [1:0]       status_o,
  output logic [IdxW-1:0]  entry_index_o
);

  // Memories; bucket heads are zeroed by a clearing pass after reset.
  logic [IdxW-1:0] head_mem [TableSize];
  logic [IdxW-1:0] link_mem [TableSize];
  logic [KeyW-1:0] key_mem  [TableSize];
  logic [LenW-1:0] len_mem  [TableSize];

  logic            op_q;
  logic [KeyW-1:0] key_q;
  logic [LenW-1:0] len_q;
  logic [HashW-1:0] hash_q, hash_d;
  logic [HashW-1:0] prod_lo_q;
  logic [MultW-1:0] prod_hi;
  logic [CharCntW-1:0] ci_q;
  logic [IdxW-1:0] cur_q, tail_q, used_q;
  logic [IdxW-1:0] clr_idx_q;
  logic [IdxW-1:0] head_rd_q, link_rd_q;
  logic [KeyW-1:0] key_rd_q;
  logic [LenW-1:0] len_rd_q;
  logic [1:0]      st_q;
  logic [IdxW-1:0] idx_q;

  logic [LenW-1:0] len_sat;
  logic [KeyW-1:0] mask;
  logic [7:0]      chr;
  logic [HashW-1:0] chr_ext;
  logic [IdxW-1:0] bucket;
  logic [IdxW-1:0] new_idx;

  // Saturate length and mask unused bytes.
  always_comb begin
    len_sat = (key_length_i > LenW'(MaxKeyChars)) ? LenW'(MaxKeyChars) : key_length_i;
    mask = '0;
    for (int i = 0; i < MaxKeyChars; i++) begin
      if (LenW'(i) < len_sat) mask[i*8 +: 8] = 8'hFF;
    end
  end

  assign chr     = key_q[{ci_q[CharCntW-2:0], 3'b000} +: 8];
  assign chr_ext = {{(HashW-8){chr[7]}}, chr};
  assign bucket  = hash_q[IdxW-1:0];
  assign new_idx = used_q + IdxW'(1);

  // Only the low half of hi32*m survives the shift by 32.
  assign prod_hi = hash_q[63:32] * hash_mult_i;

  // Hash: h*m split as lo32*m then hi32*m, one 32x32 product per cycle.
  always_comb begin
    hash_d = hash_q;
    if (cmd_i.hash_half) begin
      hash_d = prod_lo_q + {prod_hi, 32'b0} + chr_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      cur_q      <= '0;
      tail_q     <= '0;
      ci_q       <= '0;
      st_q       <= '0;
      idx_q      <= '0;
      clr_idx_q  <= '0;
    end else begin
      if (cmd_i.clear) clr_idx_q <= clr_idx_q + IdxW'(1);
      if (cmd_i.load) begin
        ci_q   <= '0;
        tail_q <= '0;
      end
      if (cmd_i.hash_step && cmd_i.hash_half) ci_q <= ci_q + CharCntW'(1);
      if (cmd_i.take_head) cur_q <= head_rd_q;
      if (cmd_i.advance) begin
        tail_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      if (cmd_i.do_insert) begin
        used_q <= new_idx;
      end
      if (cmd_i.set_result) begin
        st_q <= cmd_i.result_st;
        case (cmd_i.result_st)
          ST_FOUND:    idx_q <= cur_q;
          ST_INSERTED: idx_q <= used_q;
          default:     idx_q <= '0;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      key_q  <= key_chars_i & mask;
      len_q  <= len_sat;
      hash_q <= '0;
    end else if (cmd_i.hash_step) begin
      if (!cmd_i.hash_half) prod_lo_q <= HashW'(hash_q[31:0]) * HashW'(hash_mult_i);
      hash_q <= hash_d;
    end
  end

  // Memory ports: registered reads, single write per memory per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) begin
      head_rd_q <= head_mem[bucket];
    end
    if (cmd_i.clear) begin
      head_mem[clr_idx_q] <= '0;
    end else if (cmd_i.do_insert && tail_q == '0) begin
      head_mem[bucket] <= new_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) begin
      link_rd_q <= link_mem[cur_q];
      key_rd_q  <= key_mem[cur_q];
      len_rd_q  <= len_mem[cur_q];
    end
    if (cmd_i.do_insert) begin
      key_mem[new_idx] <= key_q;
      len_mem[new_idx] <= len_q;
    end
  end

  // Link memory: new entry's link cleared, tail's link pointed to it.
  // Two writes fall in separate insert states via one port: new entry's link first (S_INS), then the tail's (S_LINK).
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) begin
      link_mem[new_idx] <= '0;
    end else if (cmd_i.set_result && cmd_i.result_st == ST_INSERTED && tail_q != '0) begin
      link_mem[tail_q] <= used_q;
    end
  end

  assign sts_o.clear_done = (clr_idx_q == IdxW'(TableSize - 1));
  assign sts_o.hash_done  = ({1'b0, ci_q} >= {1'b0, len_q});
  assign sts_o.cur_zero   = (cur_q == '0);
  assign sts_o.match      = (len_rd_q == len_q) && (key_rd_q == key_q);
  assign sts_o.is_insert  = (op_q == OP_INSERT);
  assign sts_o.full       = (used_q == IdxW'(TableSize - 1));

  assign status_o      = st_q;
  assign entry_index_o = idx_q;

endmodule

>>> src/chtl_ctrl.sv
// Controller: state machine sequencing hash, chain walk and insert.
module chtl_ctrl
  import chtl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  chtl_sts_t sts_i,
  output chtl_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_HLO    = 10'b0000000100,
    S_HHI    = 10'b0000001000,
    S_HEAD   = 10'b0000010000,
    S_TAKE   = 10'b0000100000,
    S_ERD    = 10'b0001000000,
    S_CMP    = 10'b0010000000,
    S_INS    = 10'b0100000000,
    S_LINK   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  assign in_stall_o  = (state_q != S_IDLE) || out_vld_q;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q && out_stall_i;
    cmd_o     = '0;
    cmd_o.result_st = ST_ABSENT;
    case (state_q)
      S_CLR: begin
        // Zero one bucket head per cycle after reset.
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_HLO;
        end
      end
      S_HLO: begin
        if (sts_i.hash_done) begin
          state_d = S_HEAD;
        end else begin
          cmd_o.hash_step = 1'b1;
          state_d = S_HHI;
        end
      end
      S_HHI: begin
        cmd_o.hash_step = 1'b1;
        cmd_o.hash_half = 1'b1;
        state_d = S_HLO;
      end
      S_HEAD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.take_head = 1'b1;
        state_d = S_ERD;
      end
      S_ERD: begin
        if (sts_i.cur_zero) begin
          // End of chain: answer absent, full or go insert.
          if (!sts_i.is_insert) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_st  = ST_ABSENT;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else if (sts_i.full) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_st  = ST_FULL;
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_INS;
          end
        end else begin
          cmd_o.ent_rd = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_st  = ST_FOUND;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_ERD;
        end
      end
      S_INS: begin
        cmd_o.do_insert = 1'b1;
        state_d = S_LINK;
      end
      S_LINK: begin
        // used_q now holds the new index; link tail and report.
        cmd_o.set_result = 1'b1;
        cmd_o.result_st  = ST_INSERTED;
        out_vld_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> verif/chained_hash_table_lookup_insert_test.sv
// Testbench for the chained hash table: directed and random lookups and inserts against a predictor.
`timescale 1ns / 1ps

module chained_hash_table_lookup_insert_test
  import chtl_pkg::*;
;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned PhaseItems = 450;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              operation_i = 1'b0;
  logic [KeyW-1:0]   key_chars_i = '0;
  logic [LenW-1:0]   key_length_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [IdxW-1:0]   entry_index_o;

  chained_hash_table_lookup_insert i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table
  logic [MultW-1:0] shadow_mult = 32'd131;
  logic [IdxW-1:0]  shadow_heads [TableSize];
  logic [IdxW-1:0]  shadow_links [TableSize];
  logic [KeyW-1:0]  shadow_keys  [TableSize];
  logic [LenW-1:0]  shadow_lens  [TableSize];
  int unsigned      shadow_used = 0;

  status_e          status_q [$];
  logic [IdxW-1:0]  index_q  [$];

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;

  typedef struct {
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
  } key_t;
  key_t recent_keys [$];

  typedef struct {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    bit              typed;
    status_e         st;
    logic [IdxW-1:0] idx;
  } row_t;

  // Hash, walk the chain and append on an insert miss, as the block does
  task automatic lookup_insert(input op_e op, input logic [KeyW-1:0] raw_key,
                               input logic [LenW-1:0] raw_len,
                               output status_e st, output logic [IdxW-1:0] idx);
    int unsigned      len;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] h;
    logic [7:0]       ch;
    logic [IdxW-1:0]  bucket, cur, tail;
    logic [IdxW-1:0]  n;
    int unsigned      steps;
    len = (raw_len > MaxKeyChars) ? MaxKeyChars : raw_len;
    key = (len >= 8) ? raw_key : raw_key & ((64'd1 << (len * 8)) - 64'd1);
    h = '0;
    for (int i = 0; i < len; i++) begin
      ch = key[i*8 +: 8];
      h = h * {32'd0, shadow_mult} + {{56{ch[7]}}, ch};
    end
    bucket = h[IdxW-1:0];
    st = ST_ABSENT;
    idx = '0;
    tail = '0;
    steps = 0;
    cur = shadow_heads[bucket];
    while (cur != 0 && steps < TableSize) begin
      if (shadow_lens[cur] == len && shadow_keys[cur] == key) begin
        st = ST_FOUND;
        idx = cur;
        break;
      end
      tail = cur;
      cur = shadow_links[cur];
      steps++;
    end
    if (st != ST_FOUND && op == OP_INSERT) begin
      if (shadow_used + 1 >= TableSize) begin
        st = ST_FULL;
      end else begin
        shadow_used++;
        n = IdxW'(shadow_used);
        shadow_links[n] = '0;
        shadow_keys[n] = key;
        shadow_lens[n] = LenW'(len);
        if (tail == 0) shadow_heads[bucket] = n;
        else shadow_links[tail] = n;
        st = ST_INSERTED;
        idx = n;
      end
    end
  endtask

  // Drive one request, hold it until taken, then record its expected answer
  task automatic send_request(input row_t r);
    status_e         st;
    logic [IdxW-1:0] idx;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= r.op;
    key_chars_i  <= r.key;
    key_length_i <= r.len;
    do @(posedge clk_i); while (in_stall_o);
    lookup_insert(r.op, r.key, r.len, st, idx);
    if (r.typed) begin
      st = r.st;
      idx = r.idx;
    end
    status_q.push_back(st);
    index_q.push_back(idx);
    requests_sent++;
  endtask

  task automatic write_mult(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegHashMult;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_mult = value;
  endtask

  task automatic drain;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // Build a random request: mostly fresh keys, some repeats with noisy upper bytes
  function automatic row_t random_row(input int unsigned insert_pct);
    row_t r;
    key_t k;
    r.typed = 1'b0;
    r.st = ST_ABSENT;
    r.idx = '0;
    r.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_QUERY;
    if (recent_keys.size() != 0 && $urandom_range(99) < 20) begin
      k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      r.key = k.key;
      r.len = k.len;
      if (k.len < 8 && $urandom_range(1)) r.key |= {$urandom, $urandom} << (k.len * 8);
      if (k.len == 8 && $urandom_range(3) == 0) r.len = LenW'($urandom_range(15, 9));
    end else begin
      r.key = {$urandom, $urandom};
      r.len = ($urandom_range(9) == 0) ? LenW'($urandom_range(15)) :
                                         LenW'($urandom_range(8, 3));
      k.key = r.key;
      k.len = r.len;
      recent_keys.push_back(k);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
    return r;
  endfunction

  // Randomly stall the result side
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (status_o == ST_FULL) full_seen++;
      if (status_q.size() == 0) begin
        $error("result with no request pending: status %0d index %0d",
               status_o, entry_index_o);
        error_count++;
      end else begin
        if (status_o !== status_q[0]) begin
          $error("status: expected %0d, got %0d", status_q[0], status_o);
          error_count++;
        end
        if (entry_index_o !== index_q[0]) begin
          $error("entry_index: expected %0d, got %0d", index_q[0], entry_index_o);
          error_count++;
        end
        void'(status_q.pop_front());
        void'(index_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("chained_hash_table_lookup_insert test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t directed [$];
    int unsigned insert_pct;
    foreach (shadow_heads[i]) shadow_heads[i] = '0;
    // Reset-state expectations, extremes, saturation, masking, sign extension
    directed = '{
      '{OP_QUERY,  64'h0,                 4'd0,  1, ST_ABSENT,   10'd0},
      '{OP_INSERT, 64'h0,                 4'd0,  1, ST_INSERTED, 10'd1},
      '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 1, ST_FOUND,   10'd1},
      '{OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1, ST_ABSENT,  10'd0},
      '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1, ST_INSERTED, 10'd2},
      '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1, ST_FOUND,  10'd2},
      '{OP_QUERY,  64'hDEAD_BEEF_1234_6261, 4'd2, 1, ST_ABSENT,  10'd0},
      '{OP_INSERT, 64'hDEAD_BEEF_1234_6261, 4'd2, 1, ST_INSERTED, 10'd3},
      '{OP_QUERY,  64'h0000_0000_0000_6261, 4'd2, 1, ST_FOUND,   10'd3},
      '{OP_INSERT, 64'h0,                 4'd3,  1, ST_INSERTED, 10'd4},
      '{OP_QUERY,  64'h0,                 4'd2,  1, ST_ABSENT,   10'd0},
      '{OP_INSERT, 64'h80,                4'd1,  1, ST_INSERTED, 10'd5},
      '{OP_INSERT, 64'h7F,                4'd1,  1, ST_INSERTED, 10'd6},
      '{OP_QUERY,  64'hFF80,              4'd1,  1, ST_FOUND,    10'd5},
      '{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1, ST_INSERTED, 10'd7},
      '{OP_INSERT, 64'h5555_5555_5555_5555, 4'd8, 1, ST_INSERTED, 10'd8},
      '{OP_INSERT, 64'h0807_0605_0403_0201, 4'd9, 0, ST_ABSENT,  10'd0},
      '{OP_QUERY,  64'h0807_0605_0403_0201, 4'd8, 0, ST_ABSENT,  10'd0},
      '{OP_QUERY,  64'h0000_0000_0000_0080, 4'd2, 0, ST_ABSENT,  10'd0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);
    in_valid_i <= 1'b0;
    drain();

    // Phases: hold multiplier, idling pattern and insert bias per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
          insert_pct = 75;
        end
        1: begin
          write_mult(32'd0);
          sender_idle_pct = 52;
          stall_pct = 0;
          insert_pct = 75;
        end
        2: begin
          write_mult(32'hFFFF_FFFF);
          sender_idle_pct = 0;
          stall_pct = 52;
          insert_pct = 95;
        end
        default: begin
          write_mult($urandom);
          sender_idle_pct = 17;
          stall_pct = 17;
          insert_pct = 75;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // Drop to full speed now and then so some stretches have no gaps
        if (n % 100 == 50 && phase != 0) begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end else if (n % 100 == 70) begin
          sender_idle_pct = (phase == 1) ? 52 : (phase == 3) ? 17 : 0;
          stall_pct = (phase == 2) ? 52 : (phase == 3) ? 17 : 0;
        end
        send_request(random_row(insert_pct));
      end
      in_valid_i <= 1'b0;
      drain();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over four multiplier settings;",
             requests_sent, results_seen);
    $display("table holds %0d entries, %0d table-full answers seen.", shadow_used, full_seen);
    if (error_count == 0 && status_q.size() == 0) begin
      $display("chained_hash_table_lookup_insert test passed");
    end else begin
      $display("chained_hash_table_lookup_insert test failed");
    end
    $finish;
  end

endmodule
